// ----- hdl/tsnb_pkg.sv -----
// ----------------------------------------------------------------------------
// tsnb_pkg: shared types and constants of the texture sampler
// Sizes, operation and register codes, and the memory port structs.
// ----------------------------------------------------------------------------
package tsnb_pkg;

  // Texture geometry and number formats
  localparam int unsigned MAX_SIDE   = 256;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned COORD_W    = 18;
  localparam int unsigned SIDE_W     = $clog2(MAX_SIDE);
  localparam int unsigned SIZE_W     = 9;
  localparam int unsigned ADDR_W     = 2 * SIDE_W;
  localparam int unsigned BANK_AW    = ADDR_W - 1;
  localparam int unsigned BANK_DEPTH = 1 << BANK_AW;
  localparam int unsigned TEXEL_W    = 32;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned NUM_CHAN   = TEXEL_W / CHAN_W;
  localparam int unsigned UCL_W      = FRAC_BITS + 1;
  localparam int unsigned XS_W       = UCL_W + SIDE_W;
  localparam int unsigned DIST_W     = UCL_W + 1;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = SIZE_W;

  // Operation codes of an input transaction
  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  // Filter modes
  typedef enum logic {
    FILT_NEAREST = 1'b0,
    FILT_BOX     = 1'b1
  } filter_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEX_WIDTH   = 2'd0,
    REG_TEX_HEIGHT  = 2'd1,
    REG_FILTER_MODE = 2'd2
  } cfg_reg_e;

  // Corner order, also the tie-break order of nearest mode
  typedef enum logic [1:0] {
    CRN_LB = 2'd0,
    CRN_LT = 2'd1,
    CRN_RB = 2'd2,
    CRN_RT = 2'd3
  } corner_e;

  // Texel write request (linear address, bank chosen by bit 0)
  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [TEXEL_W-1:0] data;
  } mem_wr_t;

  // Read request: even and odd bank index for the bottom and top rows
  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] idx_e0;
    logic [BANK_AW-1:0] idx_o0;
    logic [BANK_AW-1:0] idx_e1;
    logic [BANK_AW-1:0] idx_o1;
  } mem_rd_t;

  // Registered read data of the four read ports
  typedef struct packed {
    logic [TEXEL_W-1:0] e0;
    logic [TEXEL_W-1:0] o0;
    logic [TEXEL_W-1:0] e1;
    logic [TEXEL_W-1:0] o1;
  } mem_rdata_t;

endpackage

// ----- hdl/tsnb_tex_mem.sv -----
// ----------------------------------------------------------------------------
// tsnb_tex_mem: parity-banked texel store
// Two banks split by bit 0 of the linear address, each with one write port
// and two registered read ports. A read in the cycle of a write to the same
// entry returns the old texel.
// ----------------------------------------------------------------------------
module tsnb_tex_mem
  import tsnb_pkg::*;
(
  input  logic       clk_i,
  input  mem_wr_t    wr_i,
  input  mem_rd_t    rd_i,
  output mem_rdata_t rdata_o
);

  logic [TEXEL_W-1:0] mem_even [BANK_DEPTH];
  logic [TEXEL_W-1:0] mem_odd  [BANK_DEPTH];

  // Write port, bank picked by address parity
  always_ff @(posedge clk_i) begin
    if (wr_i.en && !wr_i.addr[0]) begin
      mem_even[wr_i.addr[ADDR_W-1:1]] <= wr_i.data;
    end
    if (wr_i.en && wr_i.addr[0]) begin
      mem_odd[wr_i.addr[ADDR_W-1:1]] <= wr_i.data;
    end
  end

  // Two read ports per bank: bottom row and top row
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_o.e0 <= mem_even[rd_i.idx_e0];
      rdata_o.o0 <= mem_odd[rd_i.idx_o0];
      rdata_o.e1 <= mem_even[rd_i.idx_e1];
      rdata_o.o1 <= mem_odd[rd_i.idx_o1];
    end
  end

endmodule

// ----- hdl/texture_sampler_nearest_box_top.sv -----
// ----------------------------------------------------------------------------
// texture_sampler_nearest_box_top: RGBA texture sampler, nearest and box
// Holds a 256x256 RGBA8 texture and samples it at clamped u, v coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a transaction is taken on each rising edge with start high
//   and busy low. busy is never raised, so one transaction per cycle is taken.
//   A write stores texel_data_i at linear address texel_addr_i; a sample reads
//   the four neighbor texels around (u, v) and returns one result.
//   Result channel: valid_o strobes for one cycle with chan0_o..chan3_o once
//   the sample has passed clamp and scale, address and corner choice, memory
//   read and filter. Results come in the order of the samples; the receiver
//   cannot hold them off.
//   Throughput is one transaction per cycle, set by the texel store: two
//   banks split by address parity, each read at two rows per cycle, so the
//   four corners come out of one access.
//   A write is committed in the cycle after it is taken, in line with the reads
//   of earlier and later samples, so samples see the writes taken before them.
//   Configuration: cfg_we_i with cfg_idx_i (0 width, 1 height, 2 filter mode)
//   and cfg_data_i, written only while no transaction is in flight.
//   Reset clears the pipeline and sets width 1, height 1, nearest mode. The
//   texel store is not cleared; texels must be written before they are read.
// ----------------------------------------------------------------------------
module texture_sampler_nearest_box_top
  import tsnb_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration write port
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  // Input transaction
  input  logic                      start,
  output logic                      busy,
  input  logic                      operation_i,
  input  logic [ADDR_W-1:0]         texel_addr_i,
  input  logic [TEXEL_W-1:0]        texel_data_i,
  input  logic signed [COORD_W-1:0] u_coord_i,
  input  logic signed [COORD_W-1:0] v_coord_i,
  // Result transaction
  output logic                      valid_o,
  output logic [CHAN_W-1:0]         chan0_o,
  output logic [CHAN_W-1:0]         chan1_o,
  output logic [CHAN_W-1:0]         chan2_o,
  output logic [CHAN_W-1:0]         chan3_o
);

  localparam logic [UCL_W-1:0] ONE = UCL_W'(1 << FRAC_BITS);

  // Configuration registers
  logic [SIZE_W-1:0] width_q, height_q;
  filter_e           mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_W'(1);
      height_q <= SIZE_W'(1);
      mode_q   <= FILT_NEAREST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_TEX_WIDTH:   width_q  <= cfg_data_i[SIZE_W-1:0];
        REG_TEX_HEIGHT:  height_q <= cfg_data_i[SIZE_W-1:0];
        REG_FILTER_MODE: mode_q   <= filter_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  // Effective sizes: zero acts as one, large values saturate
  logic [SIZE_W-1:0] w_eff, h_eff;
  logic [SIDE_W-1:0] w_m1, h_m1;

  always_comb begin
    w_eff = width_q;
    if (width_q == '0) w_eff = SIZE_W'(1);
    else if (width_q > SIZE_W'(MAX_SIDE)) w_eff = SIZE_W'(MAX_SIDE);
    h_eff = height_q;
    if (height_q == '0) h_eff = SIZE_W'(1);
    else if (height_q > SIZE_W'(MAX_SIDE)) h_eff = SIZE_W'(MAX_SIDE);
  end

  assign w_m1 = SIDE_W'(w_eff - SIZE_W'(1));
  assign h_m1 = SIDE_W'(h_eff - SIZE_W'(1));

  // The pipeline never stalls
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---------------- Stage 0: clamp to [0, 1] and scale by size - 1
  logic [UCL_W-1:0] u_cl, v_cl;
  logic [XS_W-1:0]  xs_d, ys_d;

  always_comb begin
    if (u_coord_i[COORD_W-1]) u_cl = '0;
    else if (UCL_W'(u_coord_i[COORD_W-2:0]) > ONE) u_cl = ONE;
    else u_cl = UCL_W'(u_coord_i[COORD_W-2:0]);
    if (v_coord_i[COORD_W-1]) v_cl = '0;
    else if (UCL_W'(v_coord_i[COORD_W-2:0]) > ONE) v_cl = ONE;
    else v_cl = UCL_W'(v_coord_i[COORD_W-2:0]);
  end

  assign xs_d = XS_W'(u_cl) * XS_W'(w_m1);
  assign ys_d = XS_W'(v_cl) * XS_W'(h_m1);

  logic               s1_vld_q;
  op_e                s1_op_q;
  logic [ADDR_W-1:0]  s1_addr_q;
  logic [TEXEL_W-1:0] s1_data_q;
  logic [XS_W-1:0]    s1_xs_q, s1_ys_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= op_e'(operation_i);
      s1_addr_q <= texel_addr_i;
      s1_data_q <= texel_data_i;
      s1_xs_q   <= xs_d;
      s1_ys_q   <= ys_d;
    end
  end

  // ---------------- Stage 1: corner addresses and nearest-corner choice
  logic [SIDE_W-1:0]    x1, y1;
  logic [FRAC_BITS-1:0] fx, fy;
  logic                 x_same, y_same;
  logic [UCL_W-1:0]     d_right, d_top;
  logic [DIST_W-1:0]    d00, d01, d10, d11, best;
  corner_e              pick;
  logic [ADDR_W-1:0]    a_row0, a_row1, a_up0, a_up1;
  logic                 s1_smp;
  mem_wr_t              mem_wr;
  mem_rd_t              mem_rd;
  mem_rdata_t           mem_rdata;

  assign x1 = s1_xs_q[FRAC_BITS +: SIDE_W];
  assign y1 = s1_ys_q[FRAC_BITS +: SIDE_W];
  assign fx = s1_xs_q[FRAC_BITS-1:0];
  assign fy = s1_ys_q[FRAC_BITS-1:0];

  // Right / top neighbor clamps at the last column / row
  assign x_same = (SIZE_W'(x1) + SIZE_W'(1)) >= w_eff;
  assign y_same = (SIZE_W'(y1) + SIZE_W'(1)) >= h_eff;

  // At a clamped edge the fraction is zero, so the far distance is zero too
  assign d_right = x_same ? '0 : ONE - UCL_W'(fx);
  assign d_top   = y_same ? '0 : ONE - UCL_W'(fy);

  assign d00 = DIST_W'(fx) + DIST_W'(fy);
  assign d01 = DIST_W'(fx) + DIST_W'(d_top);
  assign d10 = DIST_W'(d_right) + DIST_W'(fy);
  assign d11 = DIST_W'(d_right) + DIST_W'(d_top);

  // Strict compare keeps ties on the earlier corner
  always_comb begin
    best = d00;
    pick = CRN_LB;
    if (d01 < best) begin
      best = d01;
      pick = CRN_LT;
    end
    if (d10 < best) begin
      best = d10;
      pick = CRN_RB;
    end
    if (d11 < best) begin
      pick = CRN_RT;
    end
  end

  // Linear addresses of the bottom and top rows' left corners
  assign a_row0 = ADDR_W'(y1) * ADDR_W'(w_eff) + ADDR_W'(x1);
  assign a_row1 = y_same ? a_row0 : a_row0 + ADDR_W'(w_eff);
  assign a_up0  = a_row0 + ADDR_W'(a_row0[0]);
  assign a_up1  = a_row1 + ADDR_W'(a_row1[0]);

  assign s1_smp = s1_vld_q && (s1_op_q == OP_SAMPLE);

  always_comb begin
    mem_wr.en   = s1_vld_q && (s1_op_q == OP_WRITE);
    mem_wr.addr = s1_addr_q;
    mem_wr.data = s1_data_q;
    mem_rd.en     = s1_smp;
    mem_rd.idx_o0 = a_row0[ADDR_W-1:1];
    mem_rd.idx_e0 = a_up0[ADDR_W-1:1];
    mem_rd.idx_o1 = a_row1[ADDR_W-1:1];
    mem_rd.idx_e1 = a_up1[ADDR_W-1:1];
  end

  tsnb_tex_mem u_tex_mem (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .rd_i    (mem_rd),
    .rdata_o (mem_rdata)
  );

  // ---------------- Stage 2: memory data registered, corner info follows
  logic    s2_vld_q;
  corner_e s2_pick_q;
  logic    s2_par0_q, s2_par1_q, s2_xsame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_smp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_smp) begin
      s2_pick_q  <= pick;
      s2_par0_q  <= a_row0[0];
      s2_par1_q  <= a_row1[0];
      s2_xsame_q <= x_same;
    end
  end

  // Steer bank outputs back to corners
  logic [TEXEL_W-1:0] c_lb, c_lt, c_rb, c_rt, c_pick;
  logic [TEXEL_W-1:0] box;
  logic [CHAN_W+1:0]  ch_sum [NUM_CHAN];

  assign c_lb = s2_par0_q ? mem_rdata.o0 : mem_rdata.e0;
  assign c_lt = s2_par1_q ? mem_rdata.o1 : mem_rdata.e1;
  assign c_rb = s2_xsame_q ? c_lb : (s2_par0_q ? mem_rdata.e0 : mem_rdata.o0);
  assign c_rt = s2_xsame_q ? c_lt : (s2_par1_q ? mem_rdata.e1 : mem_rdata.o1);

  always_comb begin
    case (s2_pick_q)
      CRN_LB:  c_pick = c_lb;
      CRN_LT:  c_pick = c_lt;
      CRN_RB:  c_pick = c_rb;
      default: c_pick = c_rt;
    endcase
  end

  // Box filter: per-channel sum of four, truncated divide by four
  always_comb begin
    for (int i = 0; i < NUM_CHAN; i++) begin
      ch_sum[i] = (CHAN_W+2)'(c_lb[i*CHAN_W +: CHAN_W])
                + (CHAN_W+2)'(c_lt[i*CHAN_W +: CHAN_W])
                + (CHAN_W+2)'(c_rb[i*CHAN_W +: CHAN_W])
                + (CHAN_W+2)'(c_rt[i*CHAN_W +: CHAN_W]);
      box[i*CHAN_W +: CHAN_W] = ch_sum[i][CHAN_W+1:2];
    end
  end

  // ---------------- Stage 3: result registers
  logic [TEXEL_W-1:0] res_d, res_q;

  assign res_d = (mode_q == FILT_BOX) ? box : c_pick;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      res_q <= res_d;
    end
  end

  assign chan0_o = res_q[0*CHAN_W +: CHAN_W];
  assign chan1_o = res_q[1*CHAN_W +: CHAN_W];
  assign chan2_o = res_q[2*CHAN_W +: CHAN_W];
  assign chan3_o = res_q[3*CHAN_W +: CHAN_W];

  // ---------------- Assertions
  // Every accepted sample yields a result strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && operation_i == OP_SAMPLE) |-> ##3 valid_o)
    else $error("sample transaction produced no result");

  // Writes never produce a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && operation_i == OP_WRITE) |-> ##3 !valid_o)
    else $error("write transaction produced a result");

  // Scaled coordinates stay inside the texture
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_smp |-> (SIZE_W'(x1) < w_eff) && (SIZE_W'(y1) < h_eff))
    else $error("corner outside the texture");

  // A clamped edge only occurs with a zero fraction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_smp && x_same) |-> (fx == '0))
    else $error("clamped column with nonzero fraction");

  // Writes and reads never share a stage slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_wr.en && mem_rd.en))
    else $error("write and read issued together");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the texture sampler
// Writes texels and samples them under several texture sizes and both filter
// modes. A model of the texel store and the filter predicts every sample, and
// each result strobe is checked channel by channel against the oldest pending
// prediction. Only texels that were written before are ever sampled.
// ----------------------------------------------------------------------------
module tb_top
  import tsnb_pkg::*;
();

  localparam int unsigned RESULT_LATENCY = 3;
  localparam int unsigned SETTLE_CYCLES  = RESULT_LATENCY + 5;
  localparam int unsigned WATCHDOG_LIMIT = 500;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS    = 115;
  localparam int unsigned ONE_FIX        = 1 << FRAC_BITS;
  localparam int unsigned STORE_DEPTH    = MAX_SIDE * MAX_SIDE;

  // One sampled texel, channel 0 in the low byte
  typedef struct packed {
    logic [CHAN_W-1:0] chan3;
    logic [CHAN_W-1:0] chan2;
    logic [CHAN_W-1:0] chan1;
    logic [CHAN_W-1:0] chan0;
  } rgba_t;

  // DUT ports
  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_IDX_W-1:0]      cfg_idx_i;
  logic [CFG_DATA_W-1:0]     cfg_data_i;
  logic                      start;
  logic                      busy;
  logic                      operation_i;
  logic [ADDR_W-1:0]         texel_addr_i;
  logic [TEXEL_W-1:0]        texel_data_i;
  logic signed [COORD_W-1:0] u_coord_i;
  logic signed [COORD_W-1:0] v_coord_i;
  logic                      valid_o;
  logic [CHAN_W-1:0]         chan0_o;
  logic [CHAN_W-1:0]         chan1_o;
  logic [CHAN_W-1:0]         chan2_o;
  logic [CHAN_W-1:0]         chan3_o;

  // Shadow of the texture and the registers
  logic [TEXEL_W-1:0] texel_mem [STORE_DEPTH];
  bit                 texel_written [STORE_DEPTH];
  logic [SIZE_W-1:0]  width_reg;
  logic [SIZE_W-1:0]  height_reg;
  filter_e            mode_reg;
  rgba_t              pending_texels [$];

  // Bookkeeping
  int unsigned gap_max;
  int unsigned items_sent;
  int unsigned writes_sent;
  int unsigned nearest_sent;
  int unsigned box_sent;
  int unsigned samples_checked;
  int unsigned reg_writes;
  int unsigned error_count;
  int unsigned stall_cycles;

  texture_sampler_nearest_box_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation_i),
    .texel_addr_i (texel_addr_i),
    .texel_data_i (texel_data_i),
    .u_coord_i    (u_coord_i),
    .v_coord_i    (v_coord_i),
    .valid_o      (valid_o),
    .chan0_o      (chan0_o),
    .chan1_o      (chan1_o),
    .chan2_o      (chan2_o),
    .chan3_o      (chan3_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Size register as the sampler sees it
  function automatic int unsigned eff_side(logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_SIDE) return MAX_SIDE;
    return 32'(s);
  endfunction

  // Negative to zero, above one to one
  function automatic int unsigned clamp_unit(logic [COORD_W-1:0] raw);
    if (raw[COORD_W-1]) return 0;
    if (raw > ONE_FIX) return ONE_FIX;
    return 32'(raw);
  endfunction

  // Linear addresses and Manhattan distances of the four corners
  function automatic void locate_corners(input logic [COORD_W-1:0] u,
                                         input logic [COORD_W-1:0] v,
                                         output int unsigned addr [4],
                                         output longint corner_dist [4]);
    int unsigned w, h, xs, ys, x1, y1, x2, y2, fx, fy;
    longint dx2, dy2;
    w  = eff_side(width_reg);
    h  = eff_side(height_reg);
    xs = clamp_unit(u) * (w - 1);
    ys = clamp_unit(v) * (h - 1);
    x1 = xs >> FRAC_BITS;
    y1 = ys >> FRAC_BITS;
    x2 = (x1 + 1 >= w) ? x1 : x1 + 1;
    y2 = (y1 + 1 >= h) ? y1 : y1 + 1;
    fx = xs & (ONE_FIX - 1);
    fy = ys & (ONE_FIX - 1);
    // distance to the right or top corner is zero when it is clamped
    dx2 = (longint'(x2) << FRAC_BITS) - longint'(xs);
    dy2 = (longint'(y2) << FRAC_BITS) - longint'(ys);
    addr[int'(CRN_LB)] = y1 * w + x1;
    addr[int'(CRN_LT)] = y2 * w + x1;
    addr[int'(CRN_RB)] = y1 * w + x2;
    addr[int'(CRN_RT)] = y2 * w + x2;
    corner_dist[int'(CRN_LB)] = longint'(fx) + longint'(fy);
    corner_dist[int'(CRN_LT)] = longint'(fx) + dy2;
    corner_dist[int'(CRN_RB)] = dx2 + longint'(fy);
    corner_dist[int'(CRN_RT)] = dx2 + dy2;
  endfunction

  // Filtered texel at (u, v) under the current registers
  function automatic rgba_t filtered_texel(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    int unsigned addr [4];
    longint corner_dist [4];
    int unsigned best;
    int unsigned sum;
    rgba_t res;
    locate_corners(u, v, addr, corner_dist);
    if (mode_reg == FILT_NEAREST) begin
      // strict compare keeps the earlier corner on a tie
      best = int'(CRN_LB);
      for (int k = 1; k < 4; k++) begin
        if (corner_dist[k] < corner_dist[best]) best = k;
      end
      res = texel_mem[addr[best]];
    end else begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        sum = 0;
        for (int k = 0; k < 4; k++) sum += 32'(texel_mem[addr[k]][c*CHAN_W +: CHAN_W]);
        res[c*CHAN_W +: CHAN_W] = CHAN_W'(sum >> 2);
      end
    end
    return res;
  endfunction

  // Random coordinate: mostly in range, some on grid points, some clamped
  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return COORD_W'(ONE_FIX);
      2, 3, 4: return COORD_W'($urandom());
      5:       return COORD_W'($urandom_range(0, 16) << (FRAC_BITS - 4));
      default: return COORD_W'($urandom_range(0, ONE_FIX));
    endcase
  endfunction

  // Random size register value, mostly small
  function automatic logic [SIZE_W-1:0] rand_side();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return SIZE_W'(1);
      2:       return SIZE_W'(MAX_SIDE);
      3:       return SIZE_W'($urandom_range(MAX_SIDE + 1, (1 << SIZE_W) - 1));
      default: return SIZE_W'($urandom_range(2, 12));
    endcase
  endfunction

  // Send one input transaction and predict what it causes
  task automatic send_item(op_e op, logic [ADDR_W-1:0] addr, logic [TEXEL_W-1:0] data,
                           logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    @(negedge clk_i);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start        = 1'b1;
    operation_i  = op;
    texel_addr_i = addr;
    texel_data_i = data;
    u_coord_i    = u;
    v_coord_i    = v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    if (op == OP_WRITE) begin
      texel_mem[addr]     = data;
      texel_written[addr] = 1'b1;
      writes_sent++;
    end else begin
      pending_texels.push_back(filtered_texel(u, v));
      if (mode_reg == FILT_NEAREST) nearest_sent++;
      else box_sent++;
    end
  endtask

  // Sample at (u, v), writing any corner texel that was never written first
  task automatic sample_at(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    int unsigned addr [4];
    longint corner_dist [4];
    locate_corners(u, v, addr, corner_dist);
    for (int k = 0; k < 4; k++) begin
      if (!texel_written[addr[k]]) begin
        send_item(OP_WRITE, ADDR_W'(addr[k]), $urandom(), COORD_W'($urandom()),
                  COORD_W'($urandom()));
      end
    end
    send_item(OP_SAMPLE, ADDR_W'($urandom()), $urandom(), u, v);
  endtask

  // Stop sending and let the pipeline run empty
  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_texels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_TEX_WIDTH:   width_reg = value;
      REG_TEX_HEIGHT:  height_reg = value;
      REG_FILTER_MODE: mode_reg = filter_e'(value[0]);
      default: ;
    endcase
    reg_writes++;
  endtask

  // All three registers; upper bits of the mode write are don't care
  task automatic configure(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h, filter_e mode);
    write_reg(REG_TEX_WIDTH, w);
    write_reg(REG_TEX_HEIGHT, h);
    write_reg(REG_FILTER_MODE, {(CFG_DATA_W-1)'($urandom()), mode});
  endtask

  // Reset values: 1x1 texture, nearest, every sample lands on texel 0
  task automatic test_reset_defaults();
    send_item(OP_WRITE, '0, 32'hA5C3_0FF0, '1, '0);
    sample_at({1'b1, {(COORD_W-1){1'b0}}}, {1'b0, {(COORD_W-1){1'b1}}});
    sample_at('0, COORD_W'(ONE_FIX));
    sample_at(COORD_W'(ONE_FIX), '0);
    drain();
  endtask

  // Nearest corner choice on a 2x2 texture, ties included
  task automatic test_nearest_corners();
    configure(SIZE_W'(2), SIZE_W'(2), FILT_NEAREST);
    sample_at('0, '0);
    sample_at(COORD_W'(ONE_FIX), COORD_W'(ONE_FIX));
    sample_at(18'h08000, 18'h08000);   // all four tie
    sample_at(18'h08000, 18'h04000);   // left-bottom ties right-bottom
    sample_at(18'h0C000, 18'h0E000);
    sample_at(18'h0C000, 18'h02000);
    sample_at(18'h02000, 18'h0E000);
    drain();
  endtask

  // Box filter with saturated and mixed channels
  task automatic test_box_average();
    configure(SIZE_W'(2), SIZE_W'(2), FILT_BOX);
    send_item(OP_WRITE, ADDR_W'(0), 32'hFFFF_FFFF, '0, '0);
    send_item(OP_WRITE, ADDR_W'(1), 32'hFFFF_FFFF, '0, '0);
    send_item(OP_WRITE, ADDR_W'(2), 32'hFF00_FF00, '0, '0);
    send_item(OP_WRITE, ADDR_W'(3), 32'h0000_0001, '0, '0);
    sample_at(18'h08000, 18'h08000);
    sample_at(COORD_W'(ONE_FIX), '0);
    drain();
  endtask

  // Size registers of zero and above the maximum
  task automatic test_size_extremes();
    configure('0, {SIZE_W{1'b1}}, FILT_BOX);
    sample_at(18'h08000, COORD_W'(ONE_FIX));
    drain();
    configure(SIZE_W'(300), '0, FILT_NEAREST);
    sample_at({1'b0, {(COORD_W-1){1'b1}}}, '1);
    drain();
  endtask

  // Random mix of writes and samples under random configurations
  task automatic test_random_phases();
    int unsigned w, h, start_count;
    logic [SIZE_W-1:0] side_w;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      side_w  = (phase == RANDOM_PHASES - 1) ? SIZE_W'(MAX_SIDE) : rand_side();
      configure(side_w, rand_side(), filter_e'($urandom_range(0, 1)));
      w = eff_side(width_reg);
      h = eff_side(height_reg);
      // back-to-back phases leave no gaps at all
      gap_max = (phase % 3 == 1) ? 0 : 8;
      start_count = items_sent;
      while (items_sent - start_count < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0: send_item(OP_WRITE, ADDR_W'($urandom()), $urandom(), COORD_W'($urandom()),
                       COORD_W'($urandom()));
          1: send_item(OP_WRITE, ADDR_W'($urandom_range(0, w * h - 1)), $urandom(),
                       COORD_W'($urandom()), COORD_W'($urandom()));
          default: sample_at(rand_coord(), rand_coord());
        endcase
      end
      drain();
    end
    gap_max = 8;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    rgba_t want;
    if (rst_ni && valid_o) begin
      if (pending_texels.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("[%0t] unexpected result %h %h %h %h", $time,
                   chan3_o, chan2_o, chan1_o, chan0_o);
      end else begin
        want = pending_texels.pop_front();
        samples_checked++;
        if (chan0_o !== want.chan0 || chan1_o !== want.chan1 ||
            chan2_o !== want.chan2 || chan3_o !== want.chan3) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch chan3..0 expected %h %h %h %h got %h %h %h %h",
                     $time, want.chan3, want.chan2, want.chan1, want.chan0,
                     chan3_o, chan2_o, chan1_o, chan0_o);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction or result
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Timeout after %0d idle cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Test sequence
  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_TEX_WIDTH;
    cfg_data_i   = '0;
    start        = 1'b0;
    operation_i  = OP_WRITE;
    texel_addr_i = '0;
    texel_data_i = '0;
    u_coord_i    = '0;
    v_coord_i    = '0;
    width_reg    = SIZE_W'(1);
    height_reg   = SIZE_W'(1);
    mode_reg     = FILT_NEAREST;
    gap_max      = 8;
    stall_cycles = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_nearest_corners();
    test_box_average();
    test_size_extremes();
    test_random_phases();
    drain();

    $display("Covered %0d transactions: %0d texel writes, %0d nearest and %0d box samples",
             items_sent, writes_sent, nearest_sent, box_sent);
    $display("Checked %0d results over %0d register writes, %0d errors",
             samples_checked, reg_writes, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/tsnb_pkg.sv
hdl/tsnb_tex_mem.sv
hdl/texture_sampler_nearest_box_top.sv
test/tb_top.sv
